// ----- hw/rtl/spi_frame_message_deframer_macros.svh -----
// assertion macros for the spi frame message deframer
`ifndef SPI_FRAME_MESSAGE_DEFRAMER_MACROS_SVH
`define SPI_FRAME_MESSAGE_DEFRAMER_MACROS_SVH

// same-cycle implication
`define SFMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SFMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/sfmd_pkg.sv -----
// shared types, codes and constants of the spi frame message deframer
package sfmd_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 512;
   localparam int HDR_BYTES = 4;
   localparam logic [7:0] ENCLOSURE_MARK = 8'hFF;
   localparam int FIFO_DEPTH = 4;

   typedef enum logic [2:0] {
      PH_FRAME    = 3'd0,
      PH_TYPE_LO  = 3'd1,
      PH_TYPE_HI  = 3'd2,
      PH_COUNT_LO = 3'd3,
      PH_COUNT_HI = 3'd4,
      PH_VAL_LO   = 3'd5,
      PH_VAL_HI   = 3'd6,
      PH_IDLE     = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_BAD_ENCLOSURE = 2'd1,
      ST_SIZE          = 2'd2,
      ST_TRUNCATED     = 2'd3
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [15:0] type_code;
      logic [15:0] msg_count;
      logic [15:0] value_word;
      logic        last_in_message;
      status_type  frame_status;
   } result_type;

   typedef struct packed {
      logic [1:0] cnt;
      result_type first;
      result_type second;
   } push_type;

   function automatic status_type status_now(status_type err, phase_type ph);
      status_type s;
      if (err != ST_OK) begin
         s = err;
      end else if (ph == PH_FRAME) begin
         s = ST_BAD_ENCLOSURE;
      end else if (ph == PH_IDLE) begin
         s = ST_OK;
      end else begin
         s = ST_TRUNCATED;
      end
      return s;
   endfunction

endpackage

// ----- hw/rtl/sfmd_result_fifo.sv -----
// result queue: takes up to two results a cycle, hands out one a cycle while rsp_stall is low
module sfmd_result_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  sfmd_pkg::push_type   push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sfmd_pkg::result_type head
);
   import sfmd_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   result_type mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic pop;

   assign rsp_valid = (count_ff != '0);
   assign pop = rsp_valid && !rsp_stall;
   assign room = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push.cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.cnt == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

// ----- hw/rtl/spi_frame_message_deframer.sv -----
// spi frame message deframer top level: frame header check and message parser
// Takes one receive-buffer byte per cycle while req_stall is low and updates
// the parser state in the same cycle; results go into a four-entry queue and
// leave one per cycle on the rsp channel while rsp_stall is low. A byte that
// completes a header or value and also carries end_of_buffer yields two
// results (that result, then the frame status), so req_stall rises only
// when more than two results are waiting in the queue. With rsp_stall low
// the block sustains one byte per cycle; every result is registered in the queue.
`include "spi_frame_message_deframer_macros.svh"

module spi_frame_message_deframer #(
   parameter int BUFFER_BYTES = sfmd_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_type_code,
   output logic [15:0] rsp_msg_count,
   output logic [15:0] rsp_value_word,
   output logic        rsp_last_in_message,
   output logic [1:0]  rsp_frame_status
);
   import sfmd_pkg::*;

   localparam logic [16:0] MAX_SIZE = 17'(BUFFER_BYTES - HDR_BYTES);
   localparam logic [15:0] LAST_POS = 16'(BUFFER_BYTES - 1);

   logic [15:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] size_ff, size_in;
   logic [16:0] consumed_ff, consumed_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] left_ff, left_in;
   status_type  err_ff, err_in;

   logic       room;
   logic       req_fire;
   push_type   push;
   result_type head;

   assign req_stall = !room;
   assign req_fire = req_valid && !req_stall;

   always_comb begin
      logic        byte_hit;
      result_type  byte_res;
      result_type  stat_res;
      logic [15:0] new_count;
      logic [15:0] left_dec;

      pos_in = pos_ff;
      phase_in = phase_ff;
      size_in = size_ff;
      consumed_in = consumed_ff;
      held_in = held_ff;
      type_in = type_ff;
      count_in = count_ff;
      left_in = left_ff;
      err_in = err_ff;
      byte_hit = 1'b0;
      byte_res = '0;
      stat_res = '0;
      new_count = {req_rx_byte, held_ff};
      left_dec = left_ff - 16'd1;
      push = '0;

      if (req_fire) begin
         case (phase_ff)
            PH_FRAME: begin
               if (pos_ff == 16'd0) begin
                  if (req_rx_byte != ENCLOSURE_MARK) begin
                     err_in = ST_BAD_ENCLOSURE;
                  end
               end else if (pos_ff == 16'd1) begin
                  size_in = {8'h00, req_rx_byte};
               end else if (pos_ff == 16'd2) begin
                  size_in = {req_rx_byte, size_ff[7:0]};
               end else begin
                  if (req_rx_byte != ENCLOSURE_MARK) begin
                     err_in = ST_BAD_ENCLOSURE;
                  end
                  if (err_in == ST_OK && {1'b0, size_ff} > MAX_SIZE) begin
                     err_in = ST_SIZE;
                  end
                  if (err_in != ST_OK || size_ff == 16'd0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_TYPE_LO;
                  end
               end
            end
            PH_IDLE: begin
            end
            default: begin
               consumed_in = consumed_ff + 17'd1;
               case (phase_ff)
                  PH_TYPE_LO: begin
                     type_in = {8'h00, req_rx_byte};
                     phase_in = PH_TYPE_HI;
                  end
                  PH_TYPE_HI: begin
                     type_in = {req_rx_byte, type_ff[7:0]};
                     phase_in = PH_COUNT_LO;
                  end
                  PH_COUNT_LO, PH_VAL_LO: begin
                     held_in = req_rx_byte;
                     phase_in = (phase_ff == PH_COUNT_LO) ? PH_COUNT_HI : PH_VAL_HI;
                  end
                  PH_COUNT_HI: begin
                     count_in = new_count;
                     left_in = new_count;
                     byte_hit = 1'b1;
                     byte_res.kind = KIND_HEADER;
                     byte_res.type_code = type_ff;
                     byte_res.msg_count = new_count;
                     byte_res.last_in_message = (new_count == 16'd0);
                     if (new_count == 16'd0) begin
                        phase_in = (consumed_in >= {1'b0, size_ff}) ? PH_IDLE : PH_TYPE_LO;
                     end else begin
                        phase_in = PH_VAL_LO;
                     end
                  end
                  default: begin
                     left_in = left_dec;
                     byte_hit = 1'b1;
                     byte_res.kind = KIND_VALUE;
                     byte_res.type_code = type_ff;
                     byte_res.msg_count = count_ff;
                     byte_res.value_word = {req_rx_byte, held_ff};
                     byte_res.last_in_message = (left_dec == 16'd0);
                     if (left_dec == 16'd0) begin
                        phase_in = (consumed_in >= {1'b0, size_ff}) ? PH_IDLE : PH_TYPE_LO;
                     end else begin
                        phase_in = PH_VAL_LO;
                     end
                  end
               endcase
            end
         endcase

         if (req_end_of_buffer) begin
            stat_res.kind = KIND_STATUS;
            stat_res.frame_status = status_now(err_in, phase_in);
            push.cnt = byte_hit ? 2'd2 : 2'd1;
            push.first = byte_hit ? byte_res : stat_res;
            push.second = stat_res;
            pos_in = '0;
            phase_in = PH_FRAME;
            size_in = '0;
            consumed_in = '0;
            held_in = '0;
            type_in = '0;
            count_in = '0;
            left_in = '0;
            err_in = ST_OK;
         end else begin
            push.cnt = {1'b0, byte_hit};
            push.first = byte_res;
            if (phase_in != PH_IDLE || pos_ff < 16'(HDR_BYTES)) begin
               if (pos_ff == LAST_POS) begin
                  err_in = status_now(err_in, phase_in);
                  phase_in = PH_IDLE;
               end
               pos_in = pos_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         phase_ff <= PH_FRAME;
         size_ff <= '0;
         consumed_ff <= '0;
         held_ff <= '0;
         type_ff <= '0;
         count_ff <= '0;
         left_ff <= '0;
         err_ff <= ST_OK;
      end else begin
         pos_ff <= pos_in;
         phase_ff <= phase_in;
         size_ff <= size_in;
         consumed_ff <= consumed_in;
         held_ff <= held_in;
         type_ff <= type_in;
         count_ff <= count_in;
         left_ff <= left_in;
         err_ff <= err_in;
      end
   end

   sfmd_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind = head.kind;
   assign rsp_type_code = head.type_code;
   assign rsp_msg_count = head.msg_count;
   assign rsp_value_word = head.value_word;
   assign rsp_last_in_message = head.last_in_message;
   assign rsp_frame_status = head.frame_status;

   `SFMD_ASSERT_NEXT(a_end_clears, clock, reset, req_fire && req_end_of_buffer, pos_ff == 16'd0 && phase_ff == PH_FRAME && err_ff == ST_OK, "state not cleared after buffer end")
   `SFMD_ASSERT_IMPLY(a_stall_has_data, clock, reset, req_stall, rsp_valid, "stall with empty result queue")
   `SFMD_ASSERT_IMPLY(a_values_pending, clock, reset, phase_ff == PH_VAL_LO || phase_ff == PH_VAL_HI, left_ff != 16'd0, "value phase with no values left")
   `SFMD_ASSERT_IMPLY(a_header_pos, clock, reset, phase_ff == PH_FRAME, pos_ff < 16'(HDR_BYTES), "frame header phase past header bytes")

endmodule
